FILE: src/mmu_tw_pkg.sv
// Shared types and constants for the two-level table walker.
package mmu_tw_pkg;

  localparam int WORD_W   = 32;
  localparam int IDX_W    = 12;
  localparam int STATUS_W = 3;

  // op codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_SEG_INV = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_OOB     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_PG_INV  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd4;

  // entry bit positions
  localparam int VALID_BIT   = 0;
  localparam int UNPAGED_BIT = 3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   pa;
    logic [WORD_W-1:0]   seg;
    logic [WORD_W-1:0]   pte;
  } res_t;

endpackage

FILE: src/mmu_tw_ram.sv
// Table memory: one write port, one read port, registered read data.
module mmu_tw_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/two_level_mmu_table_walker.sv
// Two-level segment/page table walker with its own table memory.
//
// Items arrive on the in_* channel. A store (op = 0) writes table_word to
// table word word_index (mod MEM_WORDS) and returns status "stored". A
// translate (op = 1) reads the segment entry at the word picked by
// segment_table_base[31:12] and va[31:22]; an unpaged segment (bit 3 set)
// is bounds checked and resolved from that one entry, a paged one causes a
// second read of the page entry picked by seg[31:12] and va[21:12]. Every
// item gives exactly one result on the out_* channel. A new item is taken
// only once the result of the last one has moved on to the output
// register; a paged walk makes two dependent reads through the single
// read port of the table RAM. A finished result parks in the output
// register, so a stalled consumer costs nothing until the next result is
// ready to leave. MEM_WORDS must be a power of two; byte addresses alias
// modulo the table size. The table has no reset and no clearing pass:
// reading a never-written word gives undefined entry data. The user must
// write the base register through cfg_* only while the block is idle; the
// block itself does not enforce this. cfg_ready is always high.
module two_level_mmu_table_walker #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmu_tw_pkg::WORD_W-1:0]       cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [mmu_tw_pkg::IDX_W-1:0]        word_index,
  input  logic [mmu_tw_pkg::WORD_W-1:0]       table_word,
  input  logic [mmu_tw_pkg::WORD_W-1:0]       virtual_address,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mmu_tw_pkg::STATUS_W-1:0]     status,
  output logic [mmu_tw_pkg::WORD_W-1:0]       physical_address,
  output logic [mmu_tw_pkg::WORD_W-1:0]       segment_entry,
  output logic [mmu_tw_pkg::WORD_W-1:0]       page_entry
);

  import mmu_tw_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  // walk sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for an item
  localparam logic [1:0] ST_SEG  = 2'd1;  // segment entry on rd_data
  localparam logic [1:0] ST_PTE  = 2'd2;  // page entry on rd_data
  localparam logic [1:0] ST_DONE = 2'd3;  // result parked in hold

  logic [1:0]        state;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] va;
  logic [WORD_W-1:0] seg;
  res_t              hold;
  res_t              out_q;

  logic              in_xfer;
  logic              out_free;
  logic              res_fin;
  res_t              res;

  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] idx_ext;
  logic [29:0]       seg_word;
  logic [29:0]       pte_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Table base is 4 KiB aligned and the index is under 1024 words, so the
  // word address is a plain concatenation: no carry ever crosses bit 10.
  assign seg_word = {base[31:12], virtual_address[31:22]};
  assign pte_word = {rd_data[31:12], va[21:12]};
  assign idx_ext  = WORD_W'(word_index);

  assign wr_en   = in_xfer && (op == OP_STORE);
  assign wr_addr = idx_ext[AW-1:0];
  assign rd_en   = (in_xfer && (op == OP_XLATE)) || (state == ST_SEG);
  assign rd_addr = (state == ST_SEG) ? pte_word[AW-1:0] : seg_word[AW-1:0];

  mmu_tw_ram #(
    .DEPTH  (MEM_WORDS),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (table_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result of the current step. Bounds: offset >= (limit + 1) * 4096 is
  // the same as va[21:12] > limit.
  always_comb begin
    res     = '0;
    res_fin = 1'b0;
    unique case (state)
      ST_SEG: begin
        res.seg = rd_data;
        if (!rd_data[VALID_BIT]) begin
          res.status = STAT_SEG_INV;
          res_fin    = 1'b1;
        end else if (rd_data[UNPAGED_BIT]) begin
          res_fin = 1'b1;
          if (va[21:12] > rd_data[21:12]) begin
            res.status = STAT_OOB;
          end else begin
            res.status = STAT_OK;
            res.pa     = {rd_data[31:22], va[21:0]};
          end
        end
      end
      ST_PTE: begin
        res.seg = seg;
        res.pte = rd_data;
        res_fin = 1'b1;
        if (!rd_data[VALID_BIT]) begin
          res.status = STAT_PG_INV;
        end else begin
          res.status = STAT_OK;
          res.pa     = {rd_data[31:12], va[11:0]};
        end
      end
      ST_DONE: begin
        res     = hold;
        res_fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= (op == OP_STORE) ? ST_DONE : ST_SEG;
          end
        end
        ST_SEG: begin
          if (!res_fin) begin
            state <= ST_PTE;
          end else begin
            state <= out_free ? ST_IDLE : ST_DONE;
          end
        end
        ST_PTE: begin
          state <= out_free ? ST_IDLE : ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (res_fin && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      va <= virtual_address;
    end
    if (state == ST_SEG) begin
      seg <= rd_data;
    end
    if (in_xfer && (op == OP_STORE)) begin
      hold <= {STAT_STORED, {(3*WORD_W){1'b0}}};
    end else if (res_fin && !out_free && (state != ST_DONE)) begin
      hold <= res;
    end
    if (res_fin && out_free) begin
      out_q <= res;
    end
  end

  assign status           = out_q.status;
  assign physical_address = out_q.pa;
  assign segment_entry    = out_q.seg;
  assign page_entry       = out_q.pte;

`ifndef ASSERT_OFF
  a_pte_after_seg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PTE) |-> ($past(state) == ST_SEG))
    else $error("page step without segment step");

  a_seg_from_xlate: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEG) |-> $past(in_valid && in_ready && (op == OP_XLATE)))
    else $error("segment step without accepted translate");

  a_pa_zero_on_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_OK)) |-> (physical_address == '0))
    else $error("physical address set on a non-translated result");

  a_store_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_STORED)) |->
      ((segment_entry == '0) && (page_entry == '0)))
    else $error("store result carries entry data");
`endif

endmodule

FILE: tb/two_level_mmu_table_walker_tb.sv
// Self-checking testbench for the two-level segment/page table walker.
module two_level_mmu_table_walker_tb;
  import mmu_tw_pkg::*;

  localparam int MEM_WORDS      = 4096;
  localparam int PAGE_BYTES     = 4096;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on any channel
  localparam int HOLD_CYCLES    = 300;   // long consumer stall for the backpressure test
  localparam int IDLE_SLACK     = 4;     // wait after the last result before the base is rewritten
  localparam int END_SLACK      = 20;
  localparam int MAX_REPORTS    = 10;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WORD_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                op;
  logic [IDX_W-1:0]    word_index;
  logic [WORD_W-1:0]   table_word;
  logic [WORD_W-1:0]   virtual_address;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   physical_address;
  logic [WORD_W-1:0]   segment_entry;
  logic [WORD_W-1:0]   page_entry;

  // Shadow of the table and the base register, updated in transfer order.
  logic [WORD_W-1:0] tbl_mem [MEM_WORDS];
  bit                tbl_written [MEM_WORDS];
  logic [WORD_W-1:0] seg_base;

  res_t walk_results_q [$];  // one predicted result per accepted item, oldest first

  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          tx_burst;     // sender offers items back to back
  bit          rx_hold_req;  // backpressure test asks the consumer to stall
  bit          rx_holding;

  two_level_mmu_table_walker #(.MEM_WORDS(MEM_WORDS)) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .word_index       (word_index),
    .table_word       (table_word),
    .virtual_address  (virtual_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .physical_address (physical_address),
    .segment_entry    (segment_entry),
    .page_entry       (page_entry)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Address helpers. A byte address picks table word (A >> 2) mod MEM_WORDS,
  // so everything above bit 13 aliases.
  // ---------------------------------------------------------------------------
  function automatic int unsigned word_of(input logic [WORD_W-1:0] addr);
    return (addr >> 2) % MEM_WORDS;
  endfunction

  // Segment entry slot: base with its low 12 bits dropped, plus 4 * va[31:22].
  function automatic int unsigned seg_word_of(input logic [WORD_W-1:0] va);
    return word_of({seg_base[31:12], 12'b0} + {20'b0, va[31:22], 2'b00});
  endfunction

  // Page entry slot: segment entry with its low 12 bits dropped, plus 4 * va[21:12].
  function automatic int unsigned page_word_of(input logic [WORD_W-1:0] se,
                                               input logic [WORD_W-1:0] va);
    return word_of({se[31:12], 12'b0} + {20'b0, va[21:12], 2'b00});
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted item to the shadow table and queues the
  // result the walker has to return for it.
  // ---------------------------------------------------------------------------
  function automatic void record_walk(input logic kind, input logic [IDX_W-1:0] widx,
                                      input logic [WORD_W-1:0] wval,
                                      input logic [WORD_W-1:0] vaddr);
    res_t              r;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] limit;
    r = '0;
    if (kind == OP_STORE) begin
      tbl_mem[widx % MEM_WORDS]     = wval;
      tbl_written[widx % MEM_WORDS] = 1'b1;
      r.status = STAT_STORED;
    end else begin
      r.seg = tbl_mem[seg_word_of(vaddr)];
      if (!r.seg[VALID_BIT]) begin
        r.status = STAT_SEG_INV;
      end else if (r.seg[UNPAGED_BIT]) begin
        // unpaged: 22-bit offset bounded by limit field (in pages) plus one page
        off   = {10'b0, vaddr[21:0]};
        limit = {10'b0, r.seg[21:12], 12'b0} + PAGE_BYTES;
        if (off >= limit) begin
          r.status = STAT_OOB;
        end else begin
          r.status = STAT_OK;
          r.pa     = {r.seg[31:22], 22'b0} + off;
        end
      end else begin
        r.pte = tbl_mem[page_word_of(r.seg, vaddr)];
        if (!r.pte[VALID_BIT]) begin
          r.status = STAT_PG_INV;
        end else begin
          r.status = STAT_OK;
          r.pa     = {r.pte[31:12], vaddr[11:0]};
        end
      end
    end
    walk_results_q.push_back(r);
  endfunction

  // Idle length shared by both sides: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [WORD_W-1:0] rand_seg_entry();
    logic [WORD_W-1:0] e;
    e = $urandom;
    e[VALID_BIT]   = ($urandom_range(0, 99) < 85);
    e[UNPAGED_BIT] = ($urandom_range(0, 99) < 40);
    return e;
  endfunction

  function automatic logic [WORD_W-1:0] rand_page_entry();
    logic [WORD_W-1:0] e;
    e = $urandom;
    e[VALID_BIT] = ($urandom_range(0, 99) < 85);
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One item transfer. Valid stays high across back-to-back items, so it is
  // only lowered when a gap is inserted.
  task automatic send_item(input logic kind, input logic [IDX_W-1:0] widx,
                           input logic [WORD_W-1:0] wval, input logic [WORD_W-1:0] vaddr);
    int unsigned gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    op              <= kind;
    word_index      <= widx;
    table_word      <= wval;
    virtual_address <= vaddr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    record_walk(kind, widx, wval, vaddr);
    items_sent++;
  endtask

  // Well-formed walk: any entry the translation will read that was never
  // written gets a random entry stored first, then the address is translated.
  task automatic send_walk(input logic [WORD_W-1:0] va);
    int unsigned       sw;
    int unsigned       pw;
    logic [WORD_W-1:0] se;
    sw = seg_word_of(va);
    if (!tbl_written[sw]) send_item(OP_STORE, sw[IDX_W-1:0], rand_seg_entry(), $urandom);
    se = tbl_mem[sw];
    if (se[VALID_BIT] && !se[UNPAGED_BIT]) begin
      pw = page_word_of(se, va);
      if (!tbl_written[pw]) send_item(OP_STORE, pw[IDX_W-1:0], rand_page_entry(), $urandom);
    end
    // index and data fields are don't-care on a translate
    send_item(OP_XLATE, IDX_W'($urandom), $urandom, va);
  endtask

  // Block is idle once every predicted result has come back and the walker
  // has been given the slack wait to settle.
  task automatic drain_walks(input int unsigned slack);
    in_valid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (slack) @(posedge clk);
  endtask

  task automatic write_seg_base(input logic [WORD_W-1:0] value);
    drain_walks(IDLE_SLACK);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seg_base = value;
  endtask

  // Random address biased toward a few segments and pages so entries get
  // reused and deeper walks happen; each of the two fields is biased half the time.
  function automatic logic [WORD_W-1:0] rand_va();
    logic [WORD_W-1:0] va;
    va = $urandom;
    if ($urandom_range(0, 1)) va[31:22] = 10'($urandom_range(0, 15));
    if ($urandom_range(0, 1)) va[21:12] = 10'($urandom_range(0, 7));
    return va;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stores at both ends of the table and with alternating bit patterns.
  task automatic test_store_extremes();
    send_item(OP_STORE, 12'h000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_STORE, 12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_STORE, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OP_STORE, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // One walk for each outcome with base at its reset value of zero.
  task automatic test_walk_cases();
    // invalid segment (word 0 holds zero)
    send_item(OP_XLATE, 12'hFFF, 32'hFFFF_FFFF, 32'h003F_FFFF);
    // unpaged, largest limit: top offset maps to the top of the address space
    send_item(OP_STORE, 12'd1, 32'hFFFF_F009, 32'h0);
    send_item(OP_XLATE, 12'h0, 32'h0, 32'h007F_FFFF);
    // unpaged, zero limit: last byte of the first page passes, next byte is out of bounds
    send_item(OP_STORE, 12'd2, 32'h4000_0009, 32'h0);
    send_item(OP_XLATE, 12'h0, 32'h0, 32'h0080_0FFF);
    send_item(OP_XLATE, 12'h0, 32'h0, 32'h0080_1000);
    // paged segment with its page table at byte 0x2000
    send_item(OP_STORE, 12'd3,   32'h0000_2001, 32'h0);
    send_item(OP_STORE, 12'h800, 32'hFFFF_F001, 32'h0);
    send_item(OP_STORE, 12'hBFF, 32'h0000_0FFE, 32'h0);
    send_item(OP_XLATE, 12'h0, 32'h0, 32'h00C0_0FFF);   // translated
    send_item(OP_XLATE, 12'h0, 32'h0, 32'h00FF_F123);   // page invalid
    // page table at the top of the address space aliases onto word 4095
    send_item(OP_STORE, 12'd4, 32'hFFFF_F001, 32'h0);
    send_item(OP_XLATE, 12'h0, 32'h0, 32'h013F_FABC);
    // unpaged bit set but valid bit clear is still an invalid segment
    send_item(OP_STORE, 12'd5, 32'h0000_0008, 32'h0);
    send_item(OP_XLATE, 12'h0, 32'h0, 32'h0140_0000);
    // last segment slot, offset past a mid-size limit
    send_item(OP_STORE, 12'd1023, 32'h1234_5009, 32'h0);
    send_item(OP_XLATE, 12'h0, 32'h0, 32'hFFFF_FFFF);
  endtask

  // Base register extremes: all ones (window at the top of the table) and
  // low bits only, which must act as zero.
  task automatic test_base_extremes();
    write_seg_base(32'hFFFF_FFFF);
    send_walk(32'h0000_0000);
    send_walk(32'hFFFF_FFFF);
    send_walk(rand_va());
    write_seg_base(32'h0000_0FFF);
    send_walk(32'h003F_FFFF);
    send_walk(32'h00C0_0FFF);
  endtask

  // Consumer stalls for a long stretch while the sender keeps offering
  // items, so the output register fills and the walker stalls its input.
  // Valid drops first so the last item is not offered again while the
  // consumer winds up its hold.
  task automatic test_output_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    rx_hold_req = 1'b1;
    wait (rx_holding);
    tx_burst = 1'b1;
    repeat (24) send_walk(rand_va());
    tx_burst = 1'b0;
  endtask

  // Random phases, each under its own base. Mostly well-formed walks with
  // random content; the rest are stray stores anywhere in the table and
  // junk written over segment slots that walks are likely to reuse.
  task automatic test_random_walks();
    logic [WORD_W-1:0] bases [4];
    int unsigned       phase_end;
    int unsigned       r;
    int unsigned       sw;
    bases[0] = $urandom;
    bases[1] = 32'h0000_0000;
    bases[2] = 32'hFFFF_FFFF;
    bases[3] = $urandom;
    for (int p = 0; p < 4; p++) begin
      write_seg_base(bases[p]);
      tx_burst  = (p == 2);  // one phase with no sender gaps at all
      phase_end = items_sent + 95;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          send_walk(rand_va());
        end else if (r < 90) begin
          send_item(OP_STORE, IDX_W'($urandom), $urandom, $urandom);
        end else begin
          sw = seg_word_of({10'($urandom_range(0, 15)), 22'b0});
          send_item(OP_STORE, sw[IDX_W-1:0], rand_seg_entry(), $urandom);
        end
      end
    end
    tx_burst = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Consumer: random ready stalls and ready bursts, plus the long hold-off
  // requested by the backpressure test.
  // ---------------------------------------------------------------------------
  initial begin : rx_ready_gen
    int unsigned n;
    forever begin
      if (rx_hold_req) begin
        out_ready  <= 1'b0;
        rx_holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding  = 1'b0;
        rx_hold_req = 1'b0;
      end else begin
        n = idle_len();
        if (n != 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (walk_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: st=%0d pa=%h seg=%h pte=%h",
                   status, physical_address, segment_entry, page_entry);
      end else begin
        want = walk_results_q.pop_front();
        if (status !== want.status || physical_address !== want.pa ||
            segment_entry !== want.seg || page_entry !== want.pte) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected st=%0d pa=%h seg=%h pte=%h",
                     want.status, want.pa, want.seg, want.pte);
            $display("          got      st=%0d pa=%h seg=%h pte=%h",
                     status, physical_address, segment_entry, page_entry);
          end
        end
      end
    end
  end

  // Watchdog: ends the run once no channel has moved a transfer for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** two_level_mmu_table_walker: FAILED **");
      $finish;
    end
  end

  initial begin : main
    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    op              <= OP_STORE;
    word_index      <= '0;
    table_word      <= '0;
    virtual_address <= '0;
    seg_base        = '0;
    items_sent      = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    tx_burst        = 1'b0;
    rx_hold_req     = 1'b0;
    rx_holding      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_store_extremes();
    test_walk_cases();
    test_base_extremes();
    test_output_backpressure();
    test_random_walks();

    drain_walks(END_SLACK);
    if (mismatches == 0)
      $display("** two_level_mmu_table_walker: PASSED **");
    else
      $display("** two_level_mmu_table_walker: FAILED **");
    $finish;
  end

endmodule

FILE: two_level_mmu_table_walker.f
src/mmu_tw_pkg.sv
src/mmu_tw_ram.sv
src/two_level_mmu_table_walker.sv
tb/two_level_mmu_table_walker_tb.sv
